// File: rtl/spt_pkg.sv
// Shared types and constants for the spectral peak tone classifier.
package spt_pkg;

  // Frame geometry. FRAME_LENGTH must be a power of two.
  localparam int unsigned FRAME_LENGTH = 128;
  localparam int unsigned HALF_FRAME   = FRAME_LENGTH / 2;
  localparam int unsigned IDX_W        = $clog2(HALF_FRAME);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned FRAME_SHIFT  = $clog2(FRAME_LENGTH);

  // Field widths.
  localparam int unsigned BIN_W   = 16;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned PEAK_W  = 6;
  localparam int unsigned LED_W   = 3;
  localparam int unsigned TONE_W  = 15;
  localparam int unsigned SPEED_W = 9;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned PROD_W  = IDX_W + RATE_W;

  // Configuration port geometry.
  localparam int unsigned NUM_REGS   = 7;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = $clog2(NUM_REGS * 4);
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LEVEL1      = 3'd0,
    REG_LEVEL2      = 3'd1,
    REG_LEVEL3      = 3'd2,
    REG_LEVEL4      = 3'd3,
    REG_LEVEL5      = 3'd4,
    REG_DRIVE_MIN   = 3'd5,
    REG_SAMPLE_RATE = 3'd6
  } reg_idx_e;

  // Register reset values.
  localparam logic [MAG_W-1:0]  LEVEL1_RST      = 32'd25;
  localparam logic [MAG_W-1:0]  LEVEL2_RST      = 32'd50;
  localparam logic [MAG_W-1:0]  LEVEL3_RST      = 32'd75;
  localparam logic [MAG_W-1:0]  LEVEL4_RST      = 32'd100;
  localparam logic [MAG_W-1:0]  LEVEL5_RST      = 32'd125;
  localparam logic [MAG_W-1:0]  DRIVE_MIN_RST   = 32'd15;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 16'd33000;

  // Tone bands for the drive command, in hertz.
  localparam logic [TONE_W-1:0] BAND_LEFT_HZ  = 15'd905;
  localparam logic [TONE_W-1:0] BAND_RIGHT_HZ = 15'd1300;
  localparam logic [TONE_W-1:0] BAND_FWD_HZ   = 15'd2050;
  localparam logic [TONE_W-1:0] BAND_STOP_HZ  = 15'd2900;

  // Wheel speed commands.
  localparam logic [SPEED_W-1:0]        SPEED_TURN    = 9'd300;
  localparam logic [SPEED_W-1:0]        SPEED_FAST    = 9'd400;
  localparam logic [SPEED_W-1:0]        SPEED_STOP    = 9'd0;
  localparam logic signed [SPEED_W-1:0] TURN_LEFT     = 9'sd200;
  localparam logic signed [SPEED_W-1:0] TURN_RIGHT    = -9'sd200;
  localparam logic signed [SPEED_W-1:0] TURN_STRAIGHT = 9'sd0;

  // LED level codes.
  localparam logic [LED_W-1:0] LED_DARK = 3'd0;
  localparam logic [LED_W-1:0] LED_L1   = 3'd1;
  localparam logic [LED_W-1:0] LED_L2   = 3'd2;
  localparam logic [LED_W-1:0] LED_L3   = 3'd3;
  localparam logic [LED_W-1:0] LED_L4   = 3'd4;
  localparam logic [LED_W-1:0] LED_TOP  = 3'd5;

  // Live configuration seen by the datapath.
  typedef struct packed {
    logic [4:0][MAG_W-1:0] level_thr;
    logic [MAG_W-1:0]      drive_min;
    logic [RATE_W-1:0]     sample_rate;
  } cfg_t;

  // One frame's peak, handed from the front to the back.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [MAG_W-1:0] mag;
  } peak_t;

endpackage

// File: rtl/spt_bin_if.sv
// Input channel carrying one FFT bin per transfer.
interface spt_bin_if;
  import spt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [BIN_W-1:0] bin_real;
  logic signed [BIN_W-1:0] bin_imag;
  logic                    last_bin;

  modport source (output valid, bin_real, bin_imag, last_bin, input ready);
  modport sink   (input valid, bin_real, bin_imag, last_bin, output ready);
endinterface

// File: rtl/spt_res_if.sv
// Output channel carrying one classification result per transfer.
interface spt_res_if;
  import spt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [PEAK_W-1:0]         peak_index;
  logic [MAG_W-1:0]          peak_volume;
  logic [LED_W-1:0]          led_level;
  logic [TONE_W-1:0]         tone_hz;
  logic                      drive_update;
  logic [SPEED_W-1:0]        forward_speed;
  logic signed [SPEED_W-1:0] turn_speed;

  modport source (output valid, peak_index, peak_volume, led_level, tone_hz,
                  drive_update, forward_speed, turn_speed, input ready);
  modport sink   (input valid, peak_index, peak_volume, led_level, tone_hz,
                  drive_update, forward_speed, turn_speed, output ready);
endinterface

// File: rtl/spectral_peak_tone_classifier_unit.sv
// Top level of the spectral peak tone classifier.
//
// Bins of one FFT frame arrive on bin_i, one complex bin per transfer, with
// last_bin set on the final bin. Only the first half of the frame is scanned
// for the largest squared magnitude; the first maximum wins. After the last
// bin one result leaves on res_o: peak index, volume, LED level, tone in
// hertz and an optional wheel drive command.
// Throughput is one bin per cycle unless a closing bin waits on a full
// queue. A result reaches res_o through a square stage and a compare stage
// in the front, a two-entry peak queue, and a multiply stage plus an output
// register in the back.
// When the receiver stalls, the output register holds its result, the back
// stage and the queue fill, and then bin_i drops ready only when a last bin
// finds the queue full; bins inside a frame keep flowing.
// The APB port sets thresholds, drive minimum and sample rate, and should be
// written only while no frame is in flight. Reset restores register
// defaults, empties the pipeline and clears the running peak.
module spectral_peak_tone_classifier_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  spt_bin_if.sink                         bin_i,
  spt_res_if.source                       res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spt_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [spt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [spt_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import spt_pkg::*;

  cfg_t  cfg;
  logic  push, full, pop, q_valid;
  peak_t push_data, pop_data;

  spt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bin_i       (bin_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  spt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  spt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (q_valid),
    .peak_i  (pop_data),
    .pop_o   (pop),
    .res_o   (res_o)
  );
endmodule

// File: rtl/spt_regs.sv
// APB configuration registers for the classifier.
module spt_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spt_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [spt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [spt_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output spt_pkg::cfg_t                   cfg_o
);
  import spt_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write decode; writes beyond the last register are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_LEVEL1:      cfg_d.level_thr[0] = pwdata;
        REG_LEVEL2:      cfg_d.level_thr[1] = pwdata;
        REG_LEVEL3:      cfg_d.level_thr[2] = pwdata;
        REG_LEVEL4:      cfg_d.level_thr[3] = pwdata;
        REG_LEVEL5:      cfg_d.level_thr[4] = pwdata;
        REG_DRIVE_MIN:   cfg_d.drive_min    = pwdata;
        REG_SAMPLE_RATE: cfg_d.sample_rate  = pwdata[RATE_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (idx)
      REG_LEVEL1:      prdata = cfg_q.level_thr[0];
      REG_LEVEL2:      prdata = cfg_q.level_thr[1];
      REG_LEVEL3:      prdata = cfg_q.level_thr[2];
      REG_LEVEL4:      prdata = cfg_q.level_thr[3];
      REG_LEVEL5:      prdata = cfg_q.level_thr[4];
      REG_DRIVE_MIN:   prdata = cfg_q.drive_min;
      REG_SAMPLE_RATE: prdata = APB_DATA_W'(cfg_q.sample_rate);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_thr[0] <= LEVEL1_RST;
      cfg_q.level_thr[1] <= LEVEL2_RST;
      cfg_q.level_thr[2] <= LEVEL3_RST;
      cfg_q.level_thr[3] <= LEVEL4_RST;
      cfg_q.level_thr[4] <= LEVEL5_RST;
      cfg_q.drive_min    <= DRIVE_MIN_RST;
      cfg_q.sample_rate  <= SAMPLE_RATE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end
endmodule

// File: rtl/spt_front.sv
// Front end: squares each bin, tracks the frame peak, and queues it at frame end.
module spt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  spt_bin_if.sink        bin_i,
  output logic           push_o,
  output spt_pkg::peak_t push_data_o,
  input  logic           full_i
);
  import spt_pkg::*;

  // Stage 1 registers: squared parts of one bin and its frame position.
  logic             s1_valid_q, s1_valid_d;
  logic [MAG_W-1:0] s1_sq_re_q, s1_sq_im_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s1_scan_q;
  logic             s1_last_q;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] best_mag_q, best_mag_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;

  logic             accept;
  logic             s1_fire;
  logic [BIN_W-1:0] abs_re, abs_im;
  logic [MAG_W-1:0] sum;
  logic             better;

  // A bin that closes a frame waits in stage 1 while the queue is full.
  assign s1_fire     = s1_valid_q && (!s1_last_q || !full_i);
  assign bin_i.ready = !s1_valid_q || s1_fire;
  assign accept      = bin_i.valid && bin_i.ready;

  // Magnitudes of both parts; the most negative code maps to 2^15.
  assign abs_re = bin_i.bin_real[BIN_W-1] ? (~bin_i.bin_real + BIN_W'(1)) : bin_i.bin_real;
  assign abs_im = bin_i.bin_imag[BIN_W-1] ? (~bin_i.bin_imag + BIN_W'(1)) : bin_i.bin_imag;

  // Bin counter saturates at half the frame and restarts after the last bin.
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (bin_i.last_bin) begin
        cnt_d = '0;
      end else if (cnt_q < CNT_W'(HALF_FRAME)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  assign s1_valid_d = accept || (s1_valid_q && !s1_fire);

  // Stage 2: sum and compare; only a strictly larger value takes over.
  assign sum    = s1_sq_re_q + s1_sq_im_q;
  assign better = s1_scan_q && (sum > best_mag_q);

  always_comb begin
    push_data_o.mag = better ? sum : best_mag_q;
    push_data_o.idx = better ? s1_idx_q : best_idx_q;
    best_mag_d      = best_mag_q;
    best_idx_d      = best_idx_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        best_mag_d = '0;
        best_idx_d = '0;
      end else if (better) begin
        best_mag_d = sum;
        best_idx_d = s1_idx_q;
      end
    end
  end

  assign push_o = s1_fire && s1_last_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      cnt_q      <= '0;
      best_mag_q <= '0;
      best_idx_q <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      cnt_q      <= cnt_d;
      best_mag_q <= best_mag_d;
      best_idx_q <= best_idx_d;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sq_re_q <= MAG_W'(abs_re) * MAG_W'(abs_re);
      s1_sq_im_q <= MAG_W'(abs_im) * MAG_W'(abs_im);
      s1_idx_q   <= cnt_q[IDX_W-1:0];
      s1_scan_q  <= cnt_q < CNT_W'(HALF_FRAME);
      s1_last_q  <= bin_i.last_bin;
    end
  end
endmodule

// File: rtl/spt_queue.sv
// Two-entry queue of frame peaks between the front and the back.
module spt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  spt_pkg::peak_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output spt_pkg::peak_t pop_data_o
);
  import spt_pkg::*;

  peak_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = count_q == 2'd2;
  assign valid_o    = count_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end
endmodule

// File: rtl/spt_back.sv
// Back end: turns a frame peak into tone, LED level and drive command.
module spt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spt_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  input  spt_pkg::peak_t peak_i,
  output logic           pop_o,
  spt_res_if.source      res_o
);
  import spt_pkg::*;

  // Stage b1: tone product, LED level.
  logic             b1_valid_q;
  logic [IDX_W-1:0] b1_idx_q;
  logic [MAG_W-1:0] b1_vol_q;
  logic [LED_W-1:0] b1_led_q;
  logic [TONE_W-1:0] b1_tone_q;

  logic              out_valid_q;
  logic              out_adv, b1_load;
  logic [PROD_W-1:0] prod;
  logic [LED_W-1:0]  led;

  logic                      upd;
  logic [SPEED_W-1:0]        fwd;
  logic signed [SPEED_W-1:0] turn;

  assign out_adv = b1_valid_q && (!out_valid_q || res_o.ready);
  assign b1_load = !b1_valid_q || out_adv;
  assign pop_o   = valid_i && b1_load;

  assign prod = PROD_W'(peak_i.idx) * PROD_W'(cfg_i.sample_rate);

  // LED level from the ordered threshold chain.
  always_comb begin
    priority if (peak_i.mag > cfg_i.level_thr[0] && peak_i.mag < cfg_i.level_thr[1]) begin
      led = LED_L1;
    end else if (peak_i.mag >= cfg_i.level_thr[1] && peak_i.mag < cfg_i.level_thr[2]) begin
      led = LED_L2;
    end else if (peak_i.mag >= cfg_i.level_thr[2] && peak_i.mag < cfg_i.level_thr[3]) begin
      led = LED_L3;
    end else if (peak_i.mag >= cfg_i.level_thr[3] && peak_i.mag < cfg_i.level_thr[4]) begin
      led = LED_L4;
    end else if (peak_i.mag >= cfg_i.level_thr[4]) begin
      led = LED_TOP;
    end else begin
      led = LED_DARK;
    end
  end

  // Drive command from the tone band, only above the minimum volume.
  always_comb begin
    upd  = 1'b0;
    fwd  = SPEED_STOP;
    turn = TURN_STRAIGHT;
    if (b1_vol_q > cfg_i.drive_min) begin
      priority if (b1_tone_q < BAND_LEFT_HZ) begin
        upd  = 1'b1;
        fwd  = SPEED_TURN;
        turn = TURN_LEFT;
      end else if (b1_tone_q < BAND_RIGHT_HZ) begin
        upd  = 1'b1;
        fwd  = SPEED_TURN;
        turn = TURN_RIGHT;
      end else if (b1_tone_q < BAND_FWD_HZ) begin
        upd  = 1'b1;
        fwd  = SPEED_FAST;
      end else if (b1_tone_q < BAND_STOP_HZ) begin
        upd  = 1'b1;
      end else begin
        upd  = 1'b0;
      end
    end
  end

  assign res_o.valid = out_valid_q;

  // Valid flags of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b1_load) begin
        b1_valid_q <= valid_i;
      end
      if (out_adv) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_idx_q  <= peak_i.idx;
      b1_vol_q  <= peak_i.mag;
      b1_led_q  <= led;
      b1_tone_q <= TONE_W'(prod >> FRAME_SHIFT);
    end
    if (out_adv) begin
      res_o.peak_index    <= PEAK_W'(b1_idx_q);
      res_o.peak_volume   <= b1_vol_q;
      res_o.led_level     <= b1_led_q;
      res_o.tone_hz       <= b1_tone_q;
      res_o.drive_update  <= upd;
      res_o.forward_speed <= fwd;
      res_o.turn_speed    <= turn;
    end
  end
endmodule
